// File: sv/rhvd_pkg.sv
`timescale 1ns / 1ps

package rhvd_pkg;

    localparam int HEADER_BYTES_MAX_DEFAULT = 128;

    localparam logic [10:0] HEADER_BITS_RESET  = 11'd660;
    localparam logic [47:0] END_PATTERN_RESET  = 48'hAAAA_AAAA_135E;
    localparam logic [23:0] SYNC_PATTERN_RESET = 24'hAA_B468;

    localparam logic [7:0] LAST_HEADER_MASK = 8'hF0;
    localparam logic [3:0] FRAME_LAST_BYTE  = 4'd11;
    localparam logic [4:0] FRAME_COUNT_LAST = 5'd20;
    localparam logic [2:0] BIT_POS_FIRST    = 3'd7;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_ACK_EVEN = 2'd1,
        OP_ACK_ODD  = 2'd2,
        OP_RESTART  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STOP_NONE = 2'd0,
        STOP_TAIL = 2'd1,
        STOP_SYNC = 2'd2
    } stop_t;

    typedef enum logic [1:0] {
        TGT_HEADER = 2'd0,
        TGT_EVEN   = 2'd1,
        TGT_ODD    = 2'd2
    } target_t;

    typedef enum logic [1:0] {
        CFG_HEADER_BITS  = 2'd0,
        CFG_END_PATTERN  = 2'd1,
        CFG_SYNC_PATTERN = 2'd2
    } cfg_addr_t;

endpackage

// File: sv/radio_header_voice_frame_deframer.sv
`timescale 1ns / 1ps

// Header and voice-frame deframer for a received radio bit stream.
// Each request on the s_ channel carries an operation in s_tuser: push the
// bit in s_tdata[0], acknowledge the even or the odd frame buffer, or
// restart. Every request produces exactly one result on the m_ channel,
// which reports the stop reason, any completed byte with its target buffer
// and index, and the header and buffer-ready flags after the step.
// The result of a request accepted at one clock edge is registered and
// presented from the next cycle onwards. One request can be accepted in
// every cycle; the rate is set by the single output register, which is
// refilled in the same cycle that the receiver takes its contents.
// When the receiver holds m_tready low, the result is held and s_tready
// drops, so nothing is lost. The configuration port writes header_bits,
// end_pattern and sync_pattern; it should only be used while the block is
// idle. Reset clears all framing state, returns the registers to their
// default values and empties the output register.
module radio_header_voice_frame_deframer #(
    parameter int HEADER_BYTES_MAX = rhvd_pkg::HEADER_BYTES_MAX_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_bit, bits 7:1 zero
    input  logic [7:0]  s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // stop_reason, byte_value, byte_index, header_done, even_ready,
    // odd_ready, bits 23:20 zero
    output logic [23:0] m_tdata,
    // byte_valid, byte_target
    output logic [2:0]  m_tuser
);
    import rhvd_pkg::*;

    logic [10:0] header_bits_reg;
    logic [47:0] end_pattern_reg;
    logic [23:0] sync_pattern_reg;

    logic [47:0] tail_window_reg, tail_window_next;
    logic [7:0]  assembly_byte_reg, assembly_byte_next;
    logic [2:0]  bit_position_reg, bit_position_next;
    logic [10:0] header_bit_count_reg, header_bit_count_next;
    logic [6:0]  header_byte_index_reg, header_byte_index_next;
    logic        header_complete_reg, header_complete_next;
    logic        header_full_reg, header_full_next;
    logic [3:0]  frame_byte_index_reg, frame_byte_index_next;
    logic [4:0]  frame_counter_reg, frame_counter_next;
    logic        odd_selected_reg, odd_selected_next;
    logic        even_flag_reg, even_flag_next;
    logic        odd_flag_reg, odd_flag_next;
    logic [15:0] frame_prev_reg, frame_prev_next;

    logic        m_tvalid_reg;
    logic [1:0]  stop_reason_reg, stop_reason_next;
    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  byte_value_reg, byte_value_next;
    logic [1:0]  byte_target_reg, byte_target_next;
    logic [6:0]  byte_index_reg, byte_index_next;

    logic        accept;
    logic        rx_bit;
    logic [7:0]  asm_new;
    logic        hdr_end;
    logic [23:0] sync_seen;
    logic [7:0]  hdr_idx_inc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign rx_bit   = s_tdata[0];

    always_comb begin
        tail_window_next       = tail_window_reg;
        assembly_byte_next     = assembly_byte_reg;
        bit_position_next      = bit_position_reg;
        header_bit_count_next  = header_bit_count_reg;
        header_byte_index_next = header_byte_index_reg;
        header_complete_next   = header_complete_reg;
        header_full_next       = header_full_reg;
        frame_byte_index_next  = frame_byte_index_reg;
        frame_counter_next     = frame_counter_reg;
        odd_selected_next      = odd_selected_reg;
        even_flag_next         = even_flag_reg;
        odd_flag_next          = odd_flag_reg;
        frame_prev_next        = frame_prev_reg;
        stop_reason_next       = STOP_NONE;
        byte_valid_next        = 1'b0;
        byte_value_next        = 8'd0;
        byte_target_next       = TGT_HEADER;
        byte_index_next        = 7'd0;

        asm_new = (assembly_byte_reg & ~(8'd1 << bit_position_reg))
                | ({7'd0, rx_bit} << bit_position_reg);
        hdr_end = !header_complete_reg
                && ((header_bit_count_reg + 11'd1) == header_bits_reg);
        sync_seen   = {frame_prev_reg, asm_new};
        hdr_idx_inc = {1'b0, header_byte_index_reg} + 8'd1;

        case (op_t'(s_tuser))
            OP_PUSH: begin
                tail_window_next = {tail_window_reg[46:0], rx_bit};
                if ({tail_window_reg[46:0], rx_bit} == end_pattern_reg) begin
                    stop_reason_next = STOP_TAIL;
                end else begin
                    assembly_byte_next = asm_new;
                    if (!header_complete_reg) begin
                        header_bit_count_next = header_bit_count_reg + 11'd1;
                    end
                    if (bit_position_reg == 3'd0 || hdr_end) begin
                        bit_position_next = BIT_POS_FIRST;
                        if (!header_complete_reg) begin
                            if (!header_full_reg) begin
                                byte_valid_next  = 1'b1;
                                byte_value_next  = hdr_end ? (asm_new & LAST_HEADER_MASK)
                                                           : asm_new;
                                byte_target_next = TGT_HEADER;
                                byte_index_next  = header_byte_index_reg;
                            end
                            if (hdr_end) begin
                                header_complete_next = 1'b1;
                            end else if (!header_full_reg) begin
                                if (hdr_idx_inc >= 8'(HEADER_BYTES_MAX)) begin
                                    header_full_next = 1'b1;
                                end else begin
                                    header_byte_index_next = hdr_idx_inc[6:0];
                                end
                            end
                        end else begin
                            byte_valid_next  = 1'b1;
                            byte_value_next  = asm_new;
                            byte_target_next = odd_selected_reg ? TGT_ODD : TGT_EVEN;
                            byte_index_next  = {3'd0, frame_byte_index_reg};
                            frame_prev_next  = sync_seen[15:0];
                            if (frame_byte_index_reg == FRAME_LAST_BYTE) begin
                                frame_byte_index_next = 4'd0;
                                if (frame_counter_reg == 5'd0) begin
                                    if (sync_seen != sync_pattern_reg) begin
                                        stop_reason_next = STOP_SYNC;
                                    end else begin
                                        frame_counter_next = 5'd1;
                                    end
                                end else begin
                                    if (odd_selected_reg) begin
                                        odd_flag_next = 1'b1;
                                    end else begin
                                        even_flag_next = 1'b1;
                                    end
                                    odd_selected_next  = !odd_selected_reg;
                                    frame_counter_next =
                                        (frame_counter_reg >= FRAME_COUNT_LAST)
                                        ? 5'd0 : frame_counter_reg + 5'd1;
                                end
                            end else begin
                                frame_byte_index_next = frame_byte_index_reg + 4'd1;
                            end
                        end
                    end else begin
                        bit_position_next = bit_position_reg - 3'd1;
                    end
                end
            end
            OP_ACK_EVEN: begin
                even_flag_next = 1'b0;
            end
            OP_ACK_ODD: begin
                odd_flag_next = 1'b0;
            end
            OP_RESTART: begin
                tail_window_next       = 48'd0;
                assembly_byte_next     = 8'd0;
                bit_position_next      = BIT_POS_FIRST;
                header_bit_count_next  = 11'd0;
                header_byte_index_next = 7'd0;
                header_complete_next   = 1'b0;
                header_full_next       = 1'b0;
                frame_byte_index_next  = 4'd0;
                frame_counter_next     = 5'd0;
                odd_selected_next      = 1'b0;
                even_flag_next         = 1'b0;
                odd_flag_next          = 1'b0;
                frame_prev_next        = 16'd0;
            end
            default: begin
                stop_reason_next = STOP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_bits_reg  <= HEADER_BITS_RESET;
            end_pattern_reg  <= END_PATTERN_RESET;
            sync_pattern_reg <= SYNC_PATTERN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_HEADER_BITS:  header_bits_reg  <= cfg_wdata[10:0];
                CFG_END_PATTERN:  end_pattern_reg  <= cfg_wdata;
                CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_wdata[23:0];
                default: header_bits_reg <= header_bits_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_window_reg       <= 48'd0;
            assembly_byte_reg     <= 8'd0;
            bit_position_reg      <= BIT_POS_FIRST;
            header_bit_count_reg  <= 11'd0;
            header_byte_index_reg <= 7'd0;
            header_complete_reg   <= 1'b0;
            header_full_reg       <= 1'b0;
            frame_byte_index_reg  <= 4'd0;
            frame_counter_reg     <= 5'd0;
            odd_selected_reg      <= 1'b0;
            even_flag_reg         <= 1'b0;
            odd_flag_reg          <= 1'b0;
            frame_prev_reg        <= 16'd0;
            m_tvalid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                tail_window_reg       <= tail_window_next;
                assembly_byte_reg     <= assembly_byte_next;
                bit_position_reg      <= bit_position_next;
                header_bit_count_reg  <= header_bit_count_next;
                header_byte_index_reg <= header_byte_index_next;
                header_complete_reg   <= header_complete_next;
                header_full_reg       <= header_full_next;
                frame_byte_index_reg  <= frame_byte_index_next;
                frame_counter_reg     <= frame_counter_next;
                odd_selected_reg      <= odd_selected_next;
                even_flag_reg         <= even_flag_next;
                odd_flag_reg          <= odd_flag_next;
                frame_prev_reg        <= frame_prev_next;
                m_tvalid_reg          <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stop_reason_reg <= stop_reason_next;
            byte_valid_reg  <= byte_valid_next;
            byte_value_reg  <= byte_value_next;
            byte_target_reg <= byte_target_next;
            byte_index_reg  <= byte_index_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, odd_flag_reg, even_flag_reg, header_complete_reg,
                       byte_index_reg, byte_value_reg, stop_reason_reg};
    assign m_tuser  = {byte_target_reg, byte_valid_reg};

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rhvd_pkg::*;

    typedef struct {
        op_t  op;
        logic rx_bit;
    } rx_request_t;

    typedef struct packed {
        stop_t       stop;
        logic        bvalid;
        logic [7:0]  bvalue;
        target_t     target;
        logic [6:0]  index;
        logic        hdone;
        logic        even;
        logic        odd;
    } deframe_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = 2'd0;
    logic [47:0] cfg_wdata = 48'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    radio_header_voice_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    rx_request_t     pending_requests[$];
    deframe_result_t expected_results[$];

    logic [10:0] hdr_bits_cfg;
    logic [47:0] end_pat_cfg;
    logic [23:0] sync_pat_cfg;

    logic [47:0] win48;
    logic [7:0]  asm_byte;
    logic [2:0]  bit_pos;
    logic [10:0] hdr_count;
    logic [6:0]  hdr_idx;
    logic        hdr_done_q;
    logic        hdr_full;
    logic [3:0]  frm_idx;
    logic [4:0]  frm_cnt;
    logic        odd_sel;
    logic        even_rdy;
    logic        odd_rdy;
    logic [15:0] frm_hist;

    int  errors = 0;
    int  requests_queued = 0;
    int  results_checked = 0;
    int  frames_seen = 0;
    int  tails_seen = 0;
    int  sync_losses = 0;
    bit  req_taken = 1'b0;
    bit  calm = 1'b0;
    bit  squeeze = 1'b0;
    bit  squeeze_started = 1'b0;
    int  stall_cycles = 0;
    bit  ack_mix = 1'b0;

    task automatic clear_framing();
        win48      = '0;
        asm_byte   = '0;
        bit_pos    = BIT_POS_FIRST;
        hdr_count  = '0;
        hdr_idx    = '0;
        hdr_done_q = 1'b0;
        hdr_full   = 1'b0;
        frm_idx    = '0;
        frm_cnt    = '0;
        odd_sel    = 1'b0;
        even_rdy   = 1'b0;
        odd_rdy    = 1'b0;
        frm_hist   = '0;
    endtask

    task automatic deframe_predict(input op_t op, input logic b, output deframe_result_t r);
        logic [23:0] seen;
        logic        last_hdr;
        r = '0;
        case (op)
            OP_PUSH: begin
                win48 = {win48[46:0], b};
                if (win48 == end_pat_cfg) begin
                    r.stop = STOP_TAIL;
                end else begin
                    asm_byte[bit_pos] = b;
                    if (!hdr_done_q) hdr_count = hdr_count + 11'd1;
                    last_hdr = !hdr_done_q && (hdr_count == hdr_bits_cfg);
                    if (bit_pos == 3'd0 || last_hdr) begin
                        bit_pos = BIT_POS_FIRST;
                        if (!hdr_done_q) begin
                            if (!hdr_full) begin
                                r.bvalid = 1'b1;
                                r.bvalue = last_hdr ? (asm_byte & LAST_HEADER_MASK) : asm_byte;
                                r.target = TGT_HEADER;
                                r.index  = hdr_idx;
                            end
                            if (last_hdr) begin
                                hdr_done_q = 1'b1;
                            end else if (!hdr_full) begin
                                if (int'(hdr_idx) + 1 >= HEADER_BYTES_MAX_DEFAULT) hdr_full = 1'b1;
                                else hdr_idx = hdr_idx + 7'd1;
                            end
                        end else begin
                            seen     = {frm_hist, asm_byte};
                            r.bvalid = 1'b1;
                            r.bvalue = asm_byte;
                            r.target = odd_sel ? TGT_ODD : TGT_EVEN;
                            r.index  = {3'd0, frm_idx};
                            frm_hist = seen[15:0];
                            if (frm_idx == FRAME_LAST_BYTE) begin
                                frm_idx = '0;
                                if (frm_cnt == 5'd0) begin
                                    if (seen != sync_pat_cfg) r.stop = STOP_SYNC;
                                    else frm_cnt = 5'd1;
                                end else begin
                                    if (odd_sel) odd_rdy = 1'b1;
                                    else even_rdy = 1'b1;
                                    odd_sel = ~odd_sel;
                                    frm_cnt = (frm_cnt >= FRAME_COUNT_LAST) ? 5'd0 : frm_cnt + 5'd1;
                                end
                            end else begin
                                frm_idx = frm_idx + 4'd1;
                            end
                        end
                    end else begin
                        bit_pos = bit_pos - 3'd1;
                    end
                end
            end
            OP_ACK_EVEN: even_rdy = 1'b0;
            OP_ACK_ODD:  odd_rdy = 1'b0;
            default:     clear_framing();
        endcase
        r.hdone = hdr_done_q;
        r.even  = even_rdy;
        r.odd   = odd_rdy;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("ERROR at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Requests: accept, predict, and remember the expected result.
    always @(posedge aclk) begin
        rx_request_t     req;
        deframe_result_t r;
        req_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            req = pending_requests.pop_front();
            deframe_predict(req.op, req.rx_bit, r);
            expected_results.push_back(r);
        end
    end

    always @(negedge aclk) begin
        if (!(s_tvalid && !req_taken)) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_requests[0].op;
                s_tdata  <= {7'd0, pending_requests[0].rx_bit};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_tready <= 1'b0;
        end else if (squeeze && !squeeze_started) begin
            squeeze_started <= 1'b1;
            stall_cycles <= 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge aclk) begin
        deframe_result_t e;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {m_tuser, m_tdata}, 0);
            end else begin
                e = expected_results.pop_front();
                results_checked++;
                if (e.stop == STOP_TAIL) tails_seen++;
                if (e.stop == STOP_SYNC) sync_losses++;
                if (e.bvalid && e.target != TGT_HEADER && e.index == 7'd11) frames_seen++;
                if (m_tdata[1:0] != e.stop) report_mismatch("stop_reason", m_tdata[1:0], e.stop);
                if (m_tuser[0] != e.bvalid) report_mismatch("byte_valid", m_tuser[0], e.bvalid);
                if (m_tdata[9:2] != e.bvalue) report_mismatch("byte_value", m_tdata[9:2], e.bvalue);
                if (m_tuser[2:1] != e.target) report_mismatch("byte_target", m_tuser[2:1], e.target);
                if (m_tdata[16:10] != e.index) report_mismatch("byte_index", m_tdata[16:10], e.index);
                if (m_tdata[17] != e.hdone) report_mismatch("header_done", m_tdata[17], e.hdone);
                if (m_tdata[18] != e.even) report_mismatch("even_ready", m_tdata[18], e.even);
                if (m_tdata[19] != e.odd) report_mismatch("odd_ready", m_tdata[19], e.odd);
            end
        end
    end

    task automatic add_req(input op_t op, input logic b);
        rx_request_t req;
        req.op = op;
        req.rx_bit = b;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic add_bit(input logic b);
        if (ack_mix && $urandom_range(0, 99) < 2)
            add_req($urandom_range(0, 1) ? OP_ACK_ODD : OP_ACK_EVEN, 1'($urandom_range(0, 1)));
        add_req(OP_PUSH, b);
    endtask

    task automatic add_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--) add_bit(v[i]);
    endtask

    task automatic add_transmission(input int nframes, input int corrupt_pct, input bit with_tail);
        int          hb;
        int          fc;
        bit          bad;
        logic [7:0]  v;
        add_req(OP_RESTART, 1'($urandom_range(0, 1)));
        hb = (hdr_bits_cfg == 11'd0) ? 2048 : int'(hdr_bits_cfg);
        repeat (hb) add_bit(1'($urandom_range(0, 1)));
        fc = 0;
        for (int f = 0; f < nframes; f++) begin
            bad = (fc == 0) && ($urandom_range(0, 99) < corrupt_pct);
            for (int k = 0; k < 12; k++) begin
                v = 8'($urandom_range(0, 255));
                if (fc == 0) begin
                    if (k == 9) v = sync_pat_cfg[23:16];
                    if (k == 10) v = sync_pat_cfg[15:8];
                    if (k == 11) v = sync_pat_cfg[7:0];
                    if (bad && k == 11) v = v ^ (8'd1 << $urandom_range(0, 7));
                end
                add_byte(v);
            end
            if (fc == 0) fc = bad ? 0 : 1;
            else fc = (fc == 20) ? 0 : fc + 1;
        end
        if (with_tail)
            for (int i = 47; i >= 0; i--) add_bit(end_pat_cfg[i]);
    endtask

    task automatic add_noise(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) add_req(OP_PUSH, 1'($urandom_range(0, 1)));
            else if (pick == 7) add_req(OP_ACK_EVEN, 1'($urandom_range(0, 1)));
            else if (pick == 8) add_req(OP_ACK_ODD, 1'($urandom_range(0, 1)));
            else add_req(OP_RESTART, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input cfg_addr_t a, input logic [47:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        case (a)
            CFG_HEADER_BITS: hdr_bits_cfg = v[10:0];
            CFG_END_PATTERN: end_pat_cfg = v;
            default:         sync_pat_cfg = v[23:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int hb;
        hdr_bits_cfg = HEADER_BITS_RESET;
        end_pat_cfg  = END_PATTERN_RESET;
        sync_pat_cfg = SYNC_PATTERN_RESET;
        clear_framing();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        add_noise(30);
        wait_drained();

        // A zero end pattern matches the empty window on the very first zero bit after a restart.
        cfg_write(CFG_HEADER_BITS, 48'd1);
        cfg_write(CFG_END_PATTERN, 48'd0);
        cfg_write(CFG_SYNC_PATTERN, 48'hFF_FFFF);
        add_req(OP_PUSH, 1'b0);
        add_req(OP_PUSH, 1'b1);
        add_req(OP_PUSH, 1'b0);
        add_req(OP_ACK_EVEN, 1'b1);
        add_req(OP_ACK_ODD, 1'b1);
        add_req(OP_PUSH, 1'b1);
        add_req(OP_RESTART, 1'b1);
        add_req(OP_PUSH, 1'b0);
        add_req(OP_PUSH, 1'b1);
        for (int i = 0; i < 8; i++) add_req(OP_PUSH, 1'b1);
        for (int i = 0; i < 8; i++) add_req(OP_PUSH, i[0]);
        wait_drained();

        ack_mix = 1'b1;
        calm = 1'b1;
        cfg_write(CFG_HEADER_BITS, 48'd20);
        cfg_write(CFG_END_PATTERN, END_PATTERN_RESET);
        cfg_write(CFG_SYNC_PATTERN, {24'd0, SYNC_PATTERN_RESET});
        add_transmission(2, 0, 1'b1);
        wait_drained();
        calm = 1'b0;

        // Partial last header byte and a long receiver stall.
        cfg_write(CFG_HEADER_BITS, 48'd12);
        cfg_write(CFG_SYNC_PATTERN, 48'd0);
        cfg_write(CFG_END_PATTERN, 48'hFFFF_FFFF_FFFF);
        squeeze = 1'b1;
        add_transmission(3, 20, 1'b1);
        wait_drained();

        while (requests_queued < 800) begin
            if ($urandom_range(0, 2) == 0) begin
                hb = $urandom_range(1, 48);
                cfg_write(CFG_HEADER_BITS, 48'(hb));
                cfg_write(CFG_END_PATTERN, 48'({$urandom, $urandom}));
                cfg_write(CFG_SYNC_PATTERN, 48'($urandom_range(0, 24'hFF_FFFF)));
            end
            if ($urandom_range(0, 4) == 0) add_noise($urandom_range(20, 60));
            else add_transmission($urandom_range(1, 2), 25, 1'($urandom_range(0, 1)));
            wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", expected_results.size(), 0);
        $display("Checked %0d results from %0d requests over several register settings.",
                 results_checked, requests_queued);
        $display("Voice frames %0d, end patterns %0d, sync losses %0d.",
                 frames_seen, tails_seen, sync_losses);
        if (errors == 0) begin
            $display("radio_header_voice_frame_deframer: match");
        end else begin
            $display("radio_header_voice_frame_deframer: mismatch");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("radio_header_voice_frame_deframer: mismatch");
        $finish;
    end

endmodule
